// ----- sv/deq_pkg.sv -----
// Shared constants, codes and the command type of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channels
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 16;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // Command queue between front and back (power of two)
  localparam int CMDQ_DEPTH = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_ROT_LEFT   = 3'd5;
  localparam logic [OP_W-1:0] OP_ROT_RIGHT  = 3'd6;
  localparam logic [OP_W-1:0] OP_SORT_CHK   = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Classified request handed from front to back
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic                    at_front;
    logic                    rd;
    logic                    rot;
    logic                    rot_left;
    logic                    chk;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    ascending;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/deq_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface deq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::OP_W-1:0]             op;
  logic signed [deq_pkg::VAL_W-1:0]     value;
  logic [deq_pkg::POS_W-1:0]            position;
  logic                                 ascending;

  modport source (output valid, op, value, position, ascending, input ready);
  modport sink   (input valid, op, value, position, ascending, output ready);
endinterface

interface deq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::VAL_W-1:0]     data;
  logic [deq_pkg::COUNT_W-1:0]          count;
  logic                                 is_empty;
  logic                                 sorted;
  logic [deq_pkg::STATUS_W-1:0]         status;

  modport source (output valid, data, count, is_empty, sorted, status, input ready);
  modport sink   (input valid, data, count, is_empty, sorted, status, output ready);
endinterface

`default_nettype wire

// ----- sv/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/deq_front.sv -----
// Request intake: decodes the op and queues classified commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module deq_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  deq_in_if.sink            in_if,
  output      logic         cmd_valid,
  input  wire logic         cmd_ready,
  output deq_pkg::cmd_t     cmd
);

  localparam int QD = deq_pkg::CMDQ_DEPTH;
  localparam int QW = $clog2(QD);

  deq_pkg::cmd_t  ent_r [QD];
  deq_pkg::cmd_t  cls;
  logic [QW-1:0]  wp_r;
  logic [QW-1:0]  rp_r;
  logic [QW:0]    cnt_r;
  logic           push;
  logic           pop;

  always_comb begin
    cls           = '0;
    cls.value     = in_if.value;
    cls.position  = in_if.position;
    cls.ascending = in_if.ascending;
    unique case (in_if.op)
      deq_pkg::OP_PUSH_BACK:  cls.push = 1'b1;
      deq_pkg::OP_PUSH_FRONT: begin
        cls.push     = 1'b1;
        cls.at_front = 1'b1;
      end
      deq_pkg::OP_POP_BACK:   cls.pop = 1'b1;
      deq_pkg::OP_POP_FRONT:  begin
        cls.pop      = 1'b1;
        cls.at_front = 1'b1;
      end
      deq_pkg::OP_READ:       cls.rd = 1'b1;
      deq_pkg::OP_ROT_LEFT:   begin
        cls.rot      = 1'b1;
        cls.rot_left = 1'b1;
      end
      deq_pkg::OP_ROT_RIGHT:  cls.rot = 1'b1;
      deq_pkg::OP_SORT_CHK:   cls.chk = 1'b1;
    endcase
  end

  assign in_if.ready = (cnt_r != (QW+1)'(QD));
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- sv/deq_mod.sv -----
// Bit-serial remainder unit: step count modulo current fill, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module deq_mod #(
  parameter int DIV_W = 9
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [deq_pkg::POS_W-1:0] num,
  input  wire logic [DIV_W-1:0]          den,
  output      logic                      done,
  output      logic [DIV_W-1:0]          rem
);

  localparam int NUM_W = deq_pkg::POS_W;
  localparam int CTW   = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CTW-1:0]   cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W-1:0] r_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] r_nxt;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {r_r, num_r[NUM_W-1]};
    if (trial >= {1'b0, den_r}) begin
      r_nxt = DIV_W'(trial - {1'b0, den_r});
    end else begin
      r_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CTW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      r_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      r_r   <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

// ----- sv/deq_back.sv -----
// Execution engine: owns the circular store, head and fill, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module deq_back #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output      logic           cmd_ready,
  input  wire deq_pkg::cmd_t  cmd,
  deq_out_if.source           out_if
);

  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int SW    = FW + 1;
  localparam int PW    = deq_pkg::POS_W;
  localparam int CW    = (FW > PW) ? FW : PW;
  localparam int VW    = deq_pkg::VAL_W;
  localparam int CNT_W = deq_pkg::COUNT_W;
  localparam int STW   = deq_pkg::STATUS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ROT_RD = 3'd3;
  localparam logic [2:0] S_ROT_WR = 3'd4;
  localparam logic [2:0] S_CHK    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;
  localparam logic [2:0] S_MOD_GO = 3'd7;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [FW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  logic [2:0]              state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  deq_pkg::cmd_t           cmd_r, cmd_nxt;
  logic [FW-1:0]           k_r, k_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [FW-1:0]           iss_r, iss_nxt;
  logic [FW-1:0]           rcv_r, rcv_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic signed [DATA_WIDTH-1:0] prev_r, prev_nxt;
  logic signed [VW-1:0]    data_r, data_nxt;
  logic                    sorted_r, sorted_nxt;
  logic [STW-1:0]          status_r, status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]    out_data_r, out_data_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_empty_r, out_empty_nxt;
  logic                    out_sorted_r, out_sorted_nxt;
  logic [STW-1:0]          out_status_r, out_status_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_rdata;
  logic signed [DATA_WIDTH-1:0] rd_word;

  logic                    mod_start;
  logic                    mod_done;
  logic [FW-1:0]           mod_rem;

  logic                    is_full;
  logic                    is_empty;
  logic [AW-1:0]           head_inc;
  logic [AW-1:0]           head_dec;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  deq_mod #(
    .DIV_W (FW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (cmd_r.position),
    .den   (fill_r),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign rd_word  = ram_rdata;
  assign is_full  = (fill_r == FW'(DEPTH));
  assign is_empty = (fill_r == '0);
  assign head_inc = wrap_inc(head_r);
  assign head_dec = wrap_dec(head_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    cmd_nxt        = cmd_r;
    k_nxt          = k_r;
    ptr_nxt        = ptr_r;
    iss_nxt        = iss_r;
    rcv_nxt        = rcv_r;
    rd_vld_nxt     = 1'b0;
    prev_nxt       = prev_r;
    data_nxt       = data_r;
    sorted_nxt     = sorted_r;
    status_nxt     = status_r;
    cmd_ready      = 1'b0;
    mod_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = head_r;
    ram_wdata      = DATA_WIDTH'(64'($signed(cmd.value)));
    ram_raddr      = head_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_sorted_nxt = out_sorted_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          data_nxt   = '0;
          sorted_nxt = 1'b0;
          status_nxt = deq_pkg::ST_OK;
          state_nxt  = S_DONE;
          priority if (cmd.push) begin
            if (is_full) begin
              status_nxt = deq_pkg::ST_FULL;
            end else begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + FW'(1);
              if (cmd.at_front) begin
                ram_waddr = head_dec;
                head_nxt  = head_dec;
              end else begin
                ram_waddr = slot(head_r, fill_r);
              end
            end
          end else if (cmd.pop) begin
            if (is_empty) begin
              status_nxt = deq_pkg::ST_EMPTY;
            end else begin
              fill_nxt = fill_r - FW'(1);
              if (cmd.at_front) begin
                head_nxt = head_inc;
              end
            end
          end else if (cmd.rd) begin
            if (CW'(cmd.position) >= CW'(fill_r)) begin
              status_nxt = deq_pkg::ST_RANGE;
            end else begin
              ram_raddr = slot(head_r, FW'(cmd.position));
              state_nxt = S_READ;
            end
          end else if (cmd.rot) begin
            if (is_empty) begin
              status_nxt = deq_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_MOD_GO;
            end
          end else begin
            sorted_nxt = 1'b1;
            ptr_nxt    = head_r;
            iss_nxt    = '0;
            rcv_nxt    = '0;
            if (fill_r > FW'(1)) begin
              state_nxt = S_CHK;
            end
          end
        end
      end

      S_READ: begin
        data_nxt  = VW'(64'(rd_word));
        state_nxt = S_DONE;
      end

      S_MOD_GO: begin
        // cmd_r holds the step count now; start the remainder once
        mod_start = 1'b1;
        state_nxt = S_MOD;
      end

      S_MOD: begin
        if (mod_done) begin
          k_nxt     = mod_rem;
          state_nxt = (mod_rem == '0) ? S_DONE : S_ROT_RD;
        end
      end

      S_ROT_RD: begin
        ram_raddr = cmd_r.rot_left ? head_r : slot(head_r, fill_r - FW'(1));
        state_nxt = S_ROT_WR;
      end

      S_ROT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (cmd_r.rot_left) begin
          ram_waddr = slot(head_r, fill_r);
          head_nxt  = head_inc;
        end else begin
          ram_waddr = head_dec;
          head_nxt  = head_dec;
        end
        k_nxt     = k_r - FW'(1);
        state_nxt = (k_r == FW'(1)) ? S_DONE : S_ROT_RD;
      end

      S_CHK: begin
        ram_raddr = ptr_r;
        if (iss_r != fill_r) begin
          ptr_nxt    = wrap_inc(ptr_r);
          iss_nxt    = iss_r + FW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          prev_nxt = rd_word;
          rcv_nxt  = rcv_r + FW'(1);
          if (rcv_r != '0) begin
            if (cmd_r.ascending ? (prev_r > rd_word) : (rd_word > prev_r)) begin
              sorted_nxt = 1'b0;
            end
          end
          if (rcv_r == fill_r - FW'(1)) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold until the result register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = data_r;
          out_count_nxt  = CNT_W'(fill_r);
          out_empty_nxt  = is_empty;
          out_sorted_nxt = sorted_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      k_r         <= (state_r == S_IDLE) ? '0 : k_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ptr_r        <= ptr_nxt;
    rcv_r        <= rcv_nxt;
    prev_r       <= prev_nxt;
    data_r       <= data_nxt;
    sorted_r     <= sorted_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_sorted_r <= out_sorted_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.data     = out_data_r;
  assign out_if.count    = out_count_r;
  assign out_if.is_empty = out_empty_r;
  assign out_if.sorted   = out_sorted_r;
  assign out_if.status   = out_status_r;

endmodule

`default_nettype wire

// ----- sv/double_ended_queue_unit.sv -----
// Double-ended queue top level: request intake, command queue and execution engine.
//
// Requests arrive on in_if (op, value, position, ascending) under valid/ready;
// one result per request leaves on out_if (data, count, is_empty, sorted,
// status) in request order. A two-entry command queue sits between intake and
// execution, so requests keep being taken while a result waits in the output
// register. Execution handles one request at a time, from dequeue to result
// register: a push, a pop, a failed read or a failed rotate (on an empty
// queue) goes straight to the result; a read first waits for the registered
// store data; a rotate by k = position mod count starts the remainder unit,
// then does a read and a write per step; a sorted check makes one store read
// per cycle.
// The store has one write and one read port with registered read data.
// Reset (rst_n low, synchronous) empties the queue: head and count go to zero;
// the store is not cleared. When out_if.ready is low the result holds, the
// engine stops after its current request and the command queue fills, after
// which in_if.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  deq_in_if.sink     in_if,
  deq_out_if.source  out_if
);

  logic           cmd_valid;
  logic           cmd_ready;
  deq_pkg::cmd_t  cmd;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

// ----- tb/tb_double_ended_queue_unit.sv -----
// Self-checking testbench for the double-ended queue unit with a shadow deque predictor.
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;

  typedef struct packed {
    logic [deq_pkg::OP_W-1:0]         op;
    logic signed [deq_pkg::VAL_W-1:0] value;
    logic [deq_pkg::POS_W-1:0]        position;
    logic                             ascending;
  } deq_req_t;

  typedef struct packed {
    logic signed [deq_pkg::VAL_W-1:0] data;
    logic [deq_pkg::COUNT_W-1:0]      count;
    logic                             is_empty;
    logic                             sorted;
    logic [deq_pkg::STATUS_W-1:0]     status;
  } deq_rsp_t;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_t;

  // Shadow copy of the deque: predicts each result and checks the results that come back.
  class deque_shadow_t;
    logic signed [deq_pkg::VAL_W-1:0] words [deq_pkg::DEPTH_DEF];
    int unsigned head_idx;
    int unsigned fill;
    deq_rsp_t    awaited [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned op_hits [8];
    int unsigned n_full, n_empty, n_range, n_sorted, peak;

    function int unsigned slot(int unsigned off);
      return (head_idx + off) % deq_pkg::DEPTH_DEF;
    endfunction

    function void note_request(deq_req_t r);
      deq_rsp_t                         x;
      int unsigned                      k;
      logic signed [deq_pkg::VAL_W-1:0] w, a, b;
      x = '0;
      op_hits[r.op]++;
      case (r.op)
        deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
          if (fill >= deq_pkg::DEPTH_DEF) begin
            x.status = deq_pkg::ST_FULL;
          end else begin
            if (r.op == deq_pkg::OP_PUSH_FRONT) begin
              head_idx = (head_idx + deq_pkg::DEPTH_DEF - 1) % deq_pkg::DEPTH_DEF;
              words[head_idx] = r.value;
            end else begin
              words[slot(fill)] = r.value;
            end
            fill++;
          end
        end
        deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT: begin
          if (fill == 0) begin
            x.status = deq_pkg::ST_EMPTY;
          end else begin
            if (r.op == deq_pkg::OP_POP_FRONT) begin
              head_idx = (head_idx + 1) % deq_pkg::DEPTH_DEF;
            end
            fill--;
          end
        end
        deq_pkg::OP_READ: begin
          if (r.position >= fill) x.status = deq_pkg::ST_RANGE;
          else x.data = words[slot(r.position)];
        end
        deq_pkg::OP_ROT_LEFT: begin
          if (fill == 0) begin
            x.status = deq_pkg::ST_EMPTY;
          end else begin
            k = r.position % fill;
            repeat (k) begin
              words[slot(fill)] = words[head_idx];
              head_idx = (head_idx + 1) % deq_pkg::DEPTH_DEF;
            end
          end
        end
        deq_pkg::OP_ROT_RIGHT: begin
          if (fill == 0) begin
            x.status = deq_pkg::ST_EMPTY;
          end else begin
            k = r.position % fill;
            repeat (k) begin
              w = words[slot(fill - 1)];
              head_idx = (head_idx + deq_pkg::DEPTH_DEF - 1) % deq_pkg::DEPTH_DEF;
              words[head_idx] = w;
            end
          end
        end
        deq_pkg::OP_SORT_CHK: begin
          x.sorted = 1'b1;
          for (int i = 0; i + 1 < fill; i++) begin
            a = words[slot(i)];
            b = words[slot(i + 1)];
            if (r.ascending ? (a > b) : (b > a)) begin
              x.sorted = 1'b0;
              break;
            end
          end
        end
      endcase
      x.count    = fill[deq_pkg::COUNT_W-1:0];
      x.is_empty = (fill == 0);
      if (fill > peak) peak = fill;
      awaited.insert(awaited.size(), x);
    endfunction

    function void check_result(deq_rsp_t got);
      deq_rsp_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: data %0d count %0d status %0d",
               got.data, got.count, got.status);
        mismatches++;
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      checked++;
      case (want.status)
        deq_pkg::ST_FULL:  n_full++;
        deq_pkg::ST_EMPTY: n_empty++;
        deq_pkg::ST_RANGE: n_range++;
        default:  ;
      endcase
      if (want.sorted) n_sorted++;
      if (got.data !== want.data) begin
        $error("data: expected %0d actual %0d", want.data, got.data);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d actual %0d", want.count, got.count);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b actual %0b", want.is_empty, got.is_empty);
        mismatches++;
      end
      if (got.sorted !== want.sorted) begin
        $error("sorted: expected %0b actual %0b", want.sorted, got.sorted);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  deque_shadow_t shadow = new();

  int unsigned sent_count;
  bit          send_steady;
  bit          recv_steady;
  bit          hold_req;
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("tb_double_ended_queue_unit: errors");
    $finish;
  end

  function automatic logic signed [deq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      4, 5:    return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic deq_req_t pick_request(mix_mode_t mix);
    deq_req_t    r;
    int unsigned roll, w_push, w_pop, n;
    n           = shadow.fill;
    r.value     = pick_value();
    r.position  = (deq_pkg::POS_W)'($urandom());
    r.ascending = 1'($urandom());
    case (mix)
      MODE_GROW:   begin w_push = 60; w_pop = 10; end
      MODE_SHRINK: begin w_push = 10; w_pop = 60; end
      default:     begin w_push = 25; w_pop = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_push) begin
      r.op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    end else if (roll < w_push + w_pop) begin
      r.op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 5) r.op = deq_pkg::OP_READ;
      else if (roll < 8) r.op = $urandom_range(0, 1) ? deq_pkg::OP_ROT_LEFT
                                                     : deq_pkg::OP_ROT_RIGHT;
      else r.op = deq_pkg::OP_SORT_CHK;
    end
    if (r.op == deq_pkg::OP_READ) begin
      roll = $urandom_range(0, 9);
      // mostly in range, sometimes right at the boundary
      if (n > 0 && roll < 8) r.position = (deq_pkg::POS_W)'($urandom_range(0, n - 1));
      else if (roll == 8) r.position = (deq_pkg::POS_W)'(n);
    end else if ((r.op == deq_pkg::OP_ROT_LEFT || r.op == deq_pkg::OP_ROT_RIGHT)
                 && $urandom_range(0, 3) != 0) begin
      r.position = (deq_pkg::POS_W)'($urandom_range(0, 2 * n + 2));
    end
    return r;
  endfunction

  task automatic send_request(input deq_req_t r);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid     <= 1'b0;
      in_ch.op        <= (deq_pkg::OP_W)'($urandom());
      in_ch.value     <= $urandom();
      in_ch.position  <= (deq_pkg::POS_W)'($urandom());
      in_ch.ascending <= 1'($urandom());
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= r.op;
    in_ch.value     <= r.value;
    in_ch.position  <= r.position;
    in_ch.ascending <= r.ascending;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    shadow.note_request(r);
    sent_count++;
  endtask

  // Drop valid so nothing is offered again, then wait out every result.
  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic drain_queue();
    deq_req_t r;
    while (shadow.fill != 0) begin
      r = pick_request(MODE_MIX);
      r.op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      send_request(r);
    end
  endtask

  // Empty the deque, then grow it from both ends so the contents stay monotonic.
  task automatic build_sorted_run(input bit rising);
    deq_req_t                         r;
    logic signed [deq_pkg::VAL_W-1:0] lo, hi;
    int unsigned                      len;
    drain_queue();
    len = $urandom_range(2, 40);
    lo  = $signed($urandom()) >>> 2;
    hi  = lo;
    repeat (len) begin
      r = pick_request(MODE_MIX);
      if ($urandom_range(0, 1)) begin
        hi      = hi + $urandom_range(0, 1000);
        r.value = hi;
        r.op    = rising ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
      end else begin
        lo      = lo - $urandom_range(0, 1000);
        r.value = lo;
        r.op    = rising ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      end
      send_request(r);
    end
    send_request('{deq_pkg::OP_SORT_CHK, 32'sd0, 16'd0, rising});
    send_request('{deq_pkg::OP_SORT_CHK, 32'sd0, 16'd0, !rising});
    r = pick_request(MODE_MIX);
    r.op = $urandom_range(0, 1) ? deq_pkg::OP_ROT_LEFT : deq_pkg::OP_ROT_RIGHT;
    send_request(r);
    send_request('{deq_pkg::OP_SORT_CHK, 32'sd0, 16'd0, rising});
  endtask

  // Result side: random stalls per transfer, plus long holds on request.
  initial begin
    deq_rsp_t    got;
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = recv_steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.data     = out_ch.data;
      got.count    = out_ch.count;
      got.is_empty = out_ch.is_empty;
      got.sorted   = out_ch.sorted;
      got.status   = out_ch.status;
      shadow.check_result(got);
    end
  end

  initial begin
    deq_req_t    r;
    mix_mode_t   mix;
    int unsigned seg_len;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = deq_pkg::OP_PUSH_BACK;
    in_ch.value     = '0;
    in_ch.position  = '0;
    in_ch.ascending = 1'b0;
    sent_count      = 0;
    send_steady     = 1'b0;
    recv_steady     = 1'b0;
    hold_req        = 1'b0;
    hold_cycles     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty-queue cases, extremes, every op
    send_request('{deq_pkg::OP_POP_BACK,   32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_POP_FRONT,  32'sd0,          16'd0,     1'b1});
    send_request('{deq_pkg::OP_READ,       32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_ROT_LEFT,   32'sd0,          16'd5,     1'b0});
    send_request('{deq_pkg::OP_ROT_RIGHT,  32'sd0,          16'hffff,  1'b0});
    send_request('{deq_pkg::OP_SORT_CHK,   32'sd0,          16'd0,     1'b1});
    send_request('{deq_pkg::OP_PUSH_BACK,  32'sh7fffffff,   16'hffff,  1'b1});
    send_request('{deq_pkg::OP_SORT_CHK,   32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_PUSH_FRONT, 32'sh80000000,   16'd0,     1'b0});
    send_request('{deq_pkg::OP_PUSH_BACK,  32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_PUSH_BACK,  -32'sd1,         16'd0,     1'b0});
    send_request('{deq_pkg::OP_READ,       32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_READ,       32'sd0,          16'd3,     1'b0});
    send_request('{deq_pkg::OP_READ,       32'sd0,          16'd4,     1'b0});
    send_request('{deq_pkg::OP_READ,       32'sd0,          16'hffff,  1'b0});
    send_request('{deq_pkg::OP_ROT_LEFT,   32'sd0,          16'hffff,  1'b0});
    send_request('{deq_pkg::OP_ROT_RIGHT,  32'sd0,          16'd8,     1'b0});
    send_request('{deq_pkg::OP_ROT_RIGHT,  32'sd0,          16'd1,     1'b0});
    send_request('{deq_pkg::OP_SORT_CHK,   32'sd0,          16'd0,     1'b1});
    send_request('{deq_pkg::OP_SORT_CHK,   32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_POP_FRONT,  32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_POP_BACK,   32'sd0,          16'd0,     1'b0});
    send_request('{deq_pkg::OP_PUSH_FRONT, 32'sh55555555,   16'haaaa,  1'b1});
    send_request('{deq_pkg::OP_READ,       32'sd0,          16'd1,     1'b0});
    send_request('{deq_pkg::OP_POP_BACK,   32'sd0,          16'd0,     1'b0});

    // Hold results back, fill to capacity, then overflow it
    hold_cycles = 400;
    hold_req    = 1'b1;
    send_steady = 1'b1;
    while (shadow.fill < deq_pkg::DEPTH_DEF) begin
      r = pick_request(MODE_MIX);
      if ($urandom_range(0, 9) != 0) begin
        r.op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      end
      send_request(r);
    end
    send_steady = 1'b0;
    repeat (4) begin
      r = pick_request(MODE_GROW);
      r.op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      send_request(r);
    end
    send_request('{deq_pkg::OP_ROT_LEFT,  32'sd0, 16'($urandom()), 1'b0});
    send_request('{deq_pkg::OP_SORT_CHK,  32'sd0, 16'd0, 1'b1});
    send_request('{deq_pkg::OP_READ,      32'sd0, 16'(deq_pkg::DEPTH_DEF - 1), 1'b0});
    send_request('{deq_pkg::OP_READ,      32'sd0, 16'(deq_pkg::DEPTH_DEF), 1'b0});
    // hold off the sender until every result is back
    wait_all_results();
    drain_queue();
    send_request('{deq_pkg::OP_POP_FRONT, 32'sd0, 16'd0, 1'b0});
    send_request('{deq_pkg::OP_POP_BACK,  32'sd0, 16'd0, 1'b0});

    build_sorted_run(1'b1);
    build_sorted_run(1'b0);

    while (sent_count < 1950) begin
      case ($urandom_range(0, 2))
        0:       mix = MODE_GROW;
        1:       mix = MODE_SHRINK;
        default: mix = MODE_MIX;
      endcase
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        hold_cycles = $urandom_range(50, 200);
        hold_req    = 1'b1;
      end
      if (sent_count + 400 < 1950 && $urandom_range(0, 4) == 0) begin
        build_sorted_run(1'($urandom_range(0, 1)));
      end
      seg_len = $urandom_range(40, 150);
      repeat (seg_len) begin
        if (sent_count < 1950) send_request(pick_request(mix));
      end
    end

    wait_all_results();
    repeat (60) @(posedge clk);

    $display("run: %0d requests and %0d results compared, peak fill %0d",
             sent_count, shadow.checked, shadow.peak);
    $display("run: %0d full drops, %0d empty hits, %0d range misses, %0d sorted answers",
             shadow.n_full, shadow.n_empty, shadow.n_range, shadow.n_sorted);
    if (shadow.mismatches == 0) begin
      $display("tb_double_ended_queue_unit: clean");
    end else begin
      $display("tb_double_ended_queue_unit: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ram.sv
sv/deq_front.sv
sv/deq_mod.sv
sv/deq_back.sv
sv/double_ended_queue_unit.sv
tb/tb_double_ended_queue_unit.sv
